@@ src/aiex_pkg.sv @@
// Shared types, codes and constants for the integer execute unit.
package aiex_pkg;

  localparam int REG_ADDR_W = 5;
  localparam int DATA_W     = 64;
  localparam int HALF_SHIFT = 16;

  // opcode classes
  localparam logic [2:0] OP_IMM_ARITH = 3'd0;
  localparam logic [2:0] OP_WIDE_MOVE = 3'd1;
  localparam logic [2:0] OP_REG_ARITH = 3'd2;
  localparam logic [2:0] OP_REG_LOGIC = 3'd3;
  localparam logic [2:0] OP_MULTIPLY  = 3'd4;

  // wide move variants
  localparam logic [1:0] MOV_N = 2'd0;
  localparam logic [1:0] MOV_Z = 2'd2;
  localparam logic [1:0] MOV_K = 2'd3;

  // logic variants
  localparam logic [1:0] LOG_ORR  = 2'd1;
  localparam logic [1:0] LOG_EOR  = 2'd2;
  localparam logic [1:0] LOG_ANDS = 2'd3;

  // shift kinds
  localparam logic [1:0] SH_LSL = 2'd0;
  localparam logic [1:0] SH_LSR = 2'd1;
  localparam logic [1:0] SH_ASR = 2'd2;
  localparam logic [1:0] SH_ROR = 2'd3;

  // error codes
  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_ROTATE   = 2'd1;
  localparam logic [1:0] ERR_UNDEF    = 2'd2;
  localparam logic [1:0] ERR_WIDE_POS = 2'd3;

  typedef struct packed {
    logic [2:0]            opcode;
    logic                  wide_64;
    logic [1:0]            op_variant;
    logic [REG_ADDR_W-1:0] dest_reg;
    logic [REG_ADDR_W-1:0] first_reg;
    logic [REG_ADDR_W-1:0] second_reg;
    logic [REG_ADDR_W-1:0] third_reg;
    logic [1:0]            shift_kind;
    logic [5:0]            shift_amount;
    logic                  invert;
    logic [15:0]           immediate;
    logic [1:0]            imm_position;
  } item_t;

  typedef struct packed {
    logic              wr;
    logic [DATA_W-1:0] value;
    logic [3:0]        flags;
    logic [1:0]        err;
    logic              halt;
  } alu_result_t;

endpackage

@@ src/aiex_rf_bank.sv @@
// One copy of the register file: one write port, one registered read port.
module aiex_rf_bank #(
  parameter int NUM_REGS = 31
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                we,
  input  logic [aiex_pkg::REG_ADDR_W-1:0]     waddr,
  input  logic [aiex_pkg::DATA_W-1:0]         wdata,
  input  logic                                re,
  input  logic [aiex_pkg::REG_ADDR_W-1:0]     raddr,
  output logic [aiex_pkg::DATA_W-1:0]         rdata
);

  localparam int IDX_W = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

  logic [aiex_pkg::DATA_W-1:0] mem [NUM_REGS];
  logic [NUM_REGS-1:0]         valid;
  logic [aiex_pkg::DATA_W-1:0] rd_raw;
  logic                        rd_ok;
  logic                        w_in_range;
  logic                        r_in_range;
  logic [IDX_W-1:0]            widx;
  logic [IDX_W-1:0]            ridx;

  assign w_in_range = (waddr < aiex_pkg::REG_ADDR_W'(NUM_REGS));
  assign r_in_range = (raddr < aiex_pkg::REG_ADDR_W'(NUM_REGS));
  assign widx       = w_in_range ? waddr[IDX_W-1:0] : '0;
  assign ridx       = r_in_range ? raddr[IDX_W-1:0] : '0;

  always_ff @(posedge clk) begin
    if (we && w_in_range) begin
      mem[widx] <= wdata;
    end
    if (re) begin
      rd_raw <= mem[ridx];
    end
  end

  // entries never written since reset read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      rd_ok <= 1'b0;
    end else begin
      if (we && w_in_range) begin
        valid[widx] <= 1'b1;
      end
      if (re) begin
        rd_ok <= r_in_range && valid[ridx];
      end
    end
  end

  assign rdata = rd_ok ? rd_raw : '0;

endmodule

@@ src/aiex_alu.sv @@
// Combinational execute logic for one data-processing request.
module aiex_alu (
  input  aiex_pkg::item_t                 item,
  input  logic [aiex_pkg::DATA_W-1:0]     op_first,
  input  logic [aiex_pkg::DATA_W-1:0]     op_second,
  input  logic [aiex_pkg::DATA_W-1:0]     op_third,
  input  logic [3:0]                      flags,
  input  logic                            halt,
  output aiex_pkg::alu_result_t           result
);

  function automatic logic [63:0] shift_operand(input logic [63:0] v, input logic [1:0] kind,
                                                input logic [5:0] amt_in, input logic w64);
    logic [5:0]   amt;
    logic [63:0]  mask;
    logic [63:0]  sx;
    logic [127:0] dbl;
    logic [63:0]  r;
    amt  = w64 ? amt_in : {1'b0, amt_in[4:0]};
    mask = w64 ? '1 : 64'h0000_0000_FFFF_FFFF;
    sx   = w64 ? v : {{32{v[31]}}, v[31:0]};
    dbl  = w64 ? {v, v} : {64'd0, v[31:0], v[31:0]};
    case (kind)
      aiex_pkg::SH_LSL: r = v << amt;
      aiex_pkg::SH_LSR: r = v >> amt;
      aiex_pkg::SH_ASR: r = $signed(sx) >>> amt;
      default:          r = 64'(dbl >> amt);
    endcase
    return r & mask;
  endfunction

  function automatic logic [3:0] arith_flags(input logic [63:0] a, input logic [63:0] b,
                                             input logic [63:0] res, input logic sub,
                                             input logic w64);
    logic sa, sb, sr, c, v, z;
    sa = w64 ? a[63] : a[31];
    sb = w64 ? b[63] : b[31];
    sr = w64 ? res[63] : res[31];
    z  = (res == '0);
    if (sub) begin
      c = (a >= b);
      v = (sa != sb) && (sr == sb);
    end else begin
      c = (res < a);
      v = (sa == sb) && (sr != sa);
    end
    return {sr, z, c, v};
  endfunction

  logic [63:0] mask;
  logic [63:0] a;
  logic [63:0] m_op;
  logic [63:0] t_op;
  logic [63:0] b_imm;
  logic [63:0] b_sh;
  logic [63:0] b_log;
  logic [63:0] arith_b;
  logic [63:0] arith_res;
  logic [63:0] logic_res;
  logic [5:0]  mov_sh;
  logic [63:0] mov_op;
  logic [63:0] mul_ll;
  logic [31:0] mul_c1;
  logic [31:0] mul_c2;
  logic [63:0] product;
  logic [63:0] mac_res;
  logic        is_sub;

  assign mask  = item.wide_64 ? '1 : 64'h0000_0000_FFFF_FFFF;
  assign a     = op_first & mask;
  assign m_op  = op_second & mask;
  assign t_op  = op_third & mask;
  assign b_imm = item.imm_position[0] ? {40'd0, item.immediate[11:0], 12'd0}
                                      : {52'd0, item.immediate[11:0]};
  assign b_sh  = shift_operand(m_op, item.shift_kind, item.shift_amount, item.wide_64);
  assign b_log = item.invert ? (~b_sh & mask) : b_sh;

  assign is_sub    = item.op_variant[1];
  assign arith_b   = (item.opcode == aiex_pkg::OP_IMM_ARITH) ? b_imm : b_sh;
  assign arith_res = (is_sub ? (a - arith_b) : (a + arith_b)) & mask;

  always_comb begin
    case (item.op_variant)
      aiex_pkg::LOG_ORR: logic_res = a | b_log;
      aiex_pkg::LOG_EOR: logic_res = a ^ b_log;
      default:           logic_res = a & b_log;
    endcase
  end

  assign mov_sh = 6'(item.imm_position * aiex_pkg::HALF_SHIFT);
  assign mov_op = {48'd0, item.immediate} << mov_sh;

  // low 64 bits of the product from three 32-bit partial products
  assign mul_ll  = a[31:0] * m_op[31:0];
  assign mul_c1  = a[31:0] * m_op[63:32];
  assign mul_c2  = a[63:32] * m_op[31:0];
  assign product = mul_ll + {mul_c1 + mul_c2, 32'd0};
  assign mac_res = (item.invert ? (t_op - product) : (t_op + product)) & mask;

  always_comb begin
    result.wr    = 1'b0;
    result.value = '0;
    result.flags = flags;
    result.err   = aiex_pkg::ERR_NONE;
    result.halt  = halt;
    if (!halt) begin
      case (item.opcode)
        aiex_pkg::OP_IMM_ARITH: begin
          result.wr    = 1'b1;
          result.value = arith_res;
          if (item.op_variant[0]) begin
            result.flags = arith_flags(a, arith_b & mask, arith_res, is_sub, item.wide_64);
          end
        end
        aiex_pkg::OP_WIDE_MOVE: begin
          if (!item.wide_64 && item.imm_position[1]) begin
            result.err = aiex_pkg::ERR_WIDE_POS;
          end else begin
            case (item.op_variant)
              aiex_pkg::MOV_N: begin
                result.wr    = 1'b1;
                result.value = ~mov_op & mask;
              end
              aiex_pkg::MOV_Z: begin
                result.wr    = 1'b1;
                result.value = mov_op & mask;
              end
              aiex_pkg::MOV_K: begin
                result.wr    = 1'b1;
                result.value = ((t_op & ~({48'd0, 16'hFFFF} << mov_sh)) | mov_op) & mask;
              end
              default: result.wr = 1'b0;
            endcase
          end
        end
        aiex_pkg::OP_REG_ARITH: begin
          if (item.shift_kind == aiex_pkg::SH_ROR) begin
            result.err  = aiex_pkg::ERR_ROTATE;
            result.halt = 1'b1;
          end else begin
            result.wr    = 1'b1;
            result.value = arith_res;
            if (item.op_variant[0]) begin
              result.flags = arith_flags(a, arith_b, arith_res, is_sub, item.wide_64);
            end
          end
        end
        aiex_pkg::OP_REG_LOGIC: begin
          result.wr    = 1'b1;
          result.value = logic_res;
          if (item.op_variant == aiex_pkg::LOG_ANDS) begin
            result.flags = {item.wide_64 ? logic_res[63] : logic_res[31],
                            logic_res == '0, 2'b00};
          end
        end
        aiex_pkg::OP_MULTIPLY: begin
          if (item.op_variant != 2'd0) begin
            result.err  = aiex_pkg::ERR_UNDEF;
            result.halt = 1'b1;
          end else begin
            result.wr    = 1'b1;
            result.value = mac_res;
          end
        end
        default: begin
          result.err  = aiex_pkg::ERR_UNDEF;
          result.halt = 1'b1;
        end
      endcase
    end
  end

endmodule

@@ src/arm64_integer_execute_unit.sv @@
// Top level of the integer execute unit: operand read, execute and result stages.
// A request is registered with its operand reads, its result in the result register.
// Throughput: one request per cycle unless out_stall holds a waiting result, set by
//   the single execute pass and the forwarding of the last write to the next request.
// Reset (rst, synchronous, active high) clears the register file valid bits, the flags,
//   the halt mark and both pipeline valids; registers then read as zero until written.
module arm64_integer_execute_unit #(
  parameter int NUM_REGS = 31
) (
  input  logic                              clk,
  input  logic                              rst,
  // request channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [2:0]                        opcode,
  input  logic                              wide_64,
  input  logic [1:0]                        op_variant,
  input  logic [aiex_pkg::REG_ADDR_W-1:0]   dest_reg,
  input  logic [aiex_pkg::REG_ADDR_W-1:0]   first_reg,
  input  logic [aiex_pkg::REG_ADDR_W-1:0]   second_reg,
  input  logic [aiex_pkg::REG_ADDR_W-1:0]   addend_reg,
  input  logic [1:0]                        shift_kind,
  input  logic [5:0]                        shift_amount,
  input  logic                              invert,
  input  logic [15:0]                       immediate,
  input  logic [1:0]                        imm_position,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              write_enable,
  output logic [aiex_pkg::REG_ADDR_W-1:0]   written_reg,
  output logic [aiex_pkg::DATA_W-1:0]       written_value,
  output logic [3:0]                        flags_nzcv,
  output logic [1:0]                        error_code,
  output logic                              halted
);

  // execute stage: request held here with its registered operand reads
  aiex_pkg::item_t     e_item;
  logic                e_valid;
  logic                in_accept;
  logic                e_fire;
  logic [aiex_pkg::REG_ADDR_W-1:0] third_addr;

  // architectural state kept outside the register file
  logic [3:0]          flags;
  logic                halt;

  // most recent register write, forwarded to the next request
  logic                              last_we;
  logic [aiex_pkg::REG_ADDR_W-1:0]   last_reg;
  logic [aiex_pkg::DATA_W-1:0]       last_val;

  logic [aiex_pkg::DATA_W-1:0] rd_first;
  logic [aiex_pkg::DATA_W-1:0] rd_second;
  logic [aiex_pkg::DATA_W-1:0] rd_third;
  logic [aiex_pkg::DATA_W-1:0] op_first;
  logic [aiex_pkg::DATA_W-1:0] op_second;
  logic [aiex_pkg::DATA_W-1:0] op_third;

  aiex_pkg::alu_result_t alu_res;
  logic                  wr_ok;

  // the execute stage moves on when the result register is free or drains this cycle
  assign e_fire    = e_valid && (!out_valid || !out_stall);
  assign in_stall  = e_valid && out_valid && out_stall;
  assign in_accept = in_valid && !in_stall;

  // third port serves the accumulator for multiply, the destination for MOVK
  assign third_addr = (opcode == aiex_pkg::OP_MULTIPLY) ? addend_reg : dest_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else if (in_accept) begin
      e_valid <= 1'b1;
    end else if (e_fire) begin
      e_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      e_item <= '{opcode:       opcode,
                  wide_64:      wide_64,
                  op_variant:   op_variant,
                  dest_reg:     dest_reg,
                  first_reg:    first_reg,
                  second_reg:   second_reg,
                  third_reg:    third_addr,
                  shift_kind:   shift_kind,
                  shift_amount: shift_amount,
                  invert:       invert,
                  immediate:    immediate,
                  imm_position: imm_position};
    end
  end

  // three copies of the register file, one read port each, all written together
  aiex_rf_bank #(.NUM_REGS(NUM_REGS)) u_bank_first (
    .clk(clk), .rst(rst),
    .we(e_fire && wr_ok), .waddr(e_item.dest_reg), .wdata(alu_res.value),
    .re(in_accept), .raddr(first_reg), .rdata(rd_first)
  );

  aiex_rf_bank #(.NUM_REGS(NUM_REGS)) u_bank_second (
    .clk(clk), .rst(rst),
    .we(e_fire && wr_ok), .waddr(e_item.dest_reg), .wdata(alu_res.value),
    .re(in_accept), .raddr(second_reg), .rdata(rd_second)
  );

  aiex_rf_bank #(.NUM_REGS(NUM_REGS)) u_bank_third (
    .clk(clk), .rst(rst),
    .we(e_fire && wr_ok), .waddr(e_item.dest_reg), .wdata(alu_res.value),
    .re(in_accept), .raddr(third_addr), .rdata(rd_third)
  );

  // the write retiring at the same edge as the read is missed by the banks; bypass it
  assign op_first  = (last_we && last_reg == e_item.first_reg)  ? last_val : rd_first;
  assign op_second = (last_we && last_reg == e_item.second_reg) ? last_val : rd_second;
  assign op_third  = (last_we && last_reg == e_item.third_reg)  ? last_val : rd_third;

  aiex_alu u_alu (
    .item(e_item),
    .op_first(op_first),
    .op_second(op_second),
    .op_third(op_third),
    .flags(flags),
    .halt(halt),
    .result(alu_res)
  );

  // writes to the zero register and beyond are dropped
  assign wr_ok = alu_res.wr && (e_item.dest_reg < aiex_pkg::REG_ADDR_W'(NUM_REGS));

  always_ff @(posedge clk) begin
    if (rst) begin
      flags   <= '0;
      halt    <= 1'b0;
      last_we <= 1'b0;
    end else if (e_fire) begin
      flags <= alu_res.flags;
      halt  <= alu_res.halt;
      if (wr_ok) begin
        last_we <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (e_fire && wr_ok) begin
      last_reg <= e_item.dest_reg;
      last_val <= alu_res.value;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (e_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (e_fire) begin
      write_enable  <= wr_ok;
      written_reg   <= wr_ok ? e_item.dest_reg : '0;
      written_value <= wr_ok ? alu_res.value : '0;
      flags_nzcv    <= alu_res.flags;
      error_code    <= alu_res.err;
      halted        <= alu_res.halt;
    end
  end

endmodule

@@ src/aiex_checker.sv @@
// Port-level assertions for the integer execute unit, bound to the top level.
module aiex_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic                              write_enable,
  input logic [aiex_pkg::REG_ADDR_W-1:0]   written_reg,
  input logic [aiex_pkg::DATA_W-1:0]       written_value,
  input logic [3:0]                        flags_nzcv,
  input logic [1:0]                        error_code,
  input logic                              halted
);

  logic seen_halt;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_halt <= 1'b0;
    end else if (out_valid && !out_stall && halted) begin
      seen_halt <= 1'b1;
    end
  end

  // a waiting result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(written_value) && $stable(written_reg)
      && $stable(write_enable) && $stable(flags_nzcv) && $stable(error_code)
      && $stable(halted))
    else $error("result changed while stalled");

  // requests are only held back by a result waiting downstream
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("request stall without a pending result");

  // halting errors write nothing and report the halt
  a_halt_err: assert property (@(posedge clk) disable iff (rst)
    out_valid && (error_code == aiex_pkg::ERR_ROTATE || error_code == aiex_pkg::ERR_UNDEF)
      |-> halted && !write_enable)
    else $error("halting error without halt");

  // once halted, every later result shows the halt and writes nothing
  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    out_valid && seen_halt |-> halted && !write_enable && error_code == aiex_pkg::ERR_NONE)
    else $error("result after halt not marked halted");

endmodule

bind arm64_integer_execute_unit aiex_checker u_aiex_checker (.*);

@@ tb/tb_arm64_integer_execute_unit.sv @@
// Self-checking testbench for the execute unit: directed, random, stall and halt tests.
`timescale 1ns / 1ps

module tb_arm64_integer_execute_unit;

  localparam int NREGS       = 31;
  localparam int CYCLE_LIMIT = 100000;

  // Codes with no name in the package
  localparam logic [2:0] OP_UNDEF_FIRST = 3'd5;
  localparam logic [2:0] OP_UNDEF_LAST  = 3'd7;
  localparam logic [1:0] ARITH_ADD      = 2'd0;
  localparam logic [1:0] ARITH_ADDS     = 2'd1;
  localparam logic [1:0] ARITH_SUB      = 2'd2;
  localparam logic [1:0] ARITH_SUBS     = 2'd3;
  localparam logic [1:0] LOG_AND        = 2'd0;
  localparam logic [1:0] MOV_NONE       = 2'd1;
  localparam logic [1:0] MUL_ACC        = 2'd0;
  localparam logic [4:0] ZERO_REG       = 5'd31;

  typedef struct {
    logic [2:0]  opcode;
    logic        wide_64;
    logic [1:0]  op_variant;
    logic [4:0]  dest_reg;
    logic [4:0]  first_reg;
    logic [4:0]  second_reg;
    logic [4:0]  addend_reg;
    logic [1:0]  shift_kind;
    logic [5:0]  shift_amount;
    logic        invert;
    logic [15:0] immediate;
    logic [1:0]  imm_position;
  } exec_req_t;

  typedef struct {
    logic        write_enable;
    logic [4:0]  written_reg;
    logic [63:0] written_value;
    logic [3:0]  flags_nzcv;
    logic [1:0]  error_code;
    logic        halted;
  } writeback_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  opcode = '0;
  logic        wide_64 = 1'b0;
  logic [1:0]  op_variant = '0;
  logic [4:0]  dest_reg = '0;
  logic [4:0]  first_reg = '0;
  logic [4:0]  second_reg = '0;
  logic [4:0]  addend_reg = '0;
  logic [1:0]  shift_kind = '0;
  logic [5:0]  shift_amount = '0;
  logic        invert = 1'b0;
  logic [15:0] immediate = '0;
  logic [1:0]  imm_position = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        write_enable;
  logic [4:0]  written_reg;
  logic [63:0] written_value;
  logic [3:0]  flags_nzcv;
  logic [1:0]  error_code;
  logic        halted;

  // Architectural state as the testbench sees it
  logic [63:0] model_regs [NREGS];
  logic [3:0]  model_nzcv = '0;
  bit          model_halt = 1'b0;

  writeback_t  pending_writebacks [$];
  int          mismatch_count = 0;
  int          cycle_count = 0;
  int          send_idle_pct = 0;   // chance per cycle that the sender holds back
  int          recv_stall_pct = 0;  // chance per cycle that the receiver stalls
  int          hold_left = 0;       // cycles of forced receiver stall still to run

  arm64_integer_execute_unit #(.NUM_REGS(NREGS)) dut (.*);

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------
  function automatic logic [63:0] width_mask(bit w);
    return w ? 64'hFFFF_FFFF_FFFF_FFFF : 64'h0000_0000_FFFF_FFFF;
  endfunction

  function automatic bit sign_of(logic [63:0] v, bit w);
    return w ? v[63] : v[31];
  endfunction

  // register 31 (and anything past the file) reads as zero
  function automatic logic [63:0] read_model_reg(logic [4:0] r, bit w);
    if (r >= NREGS) return '0;
    return model_regs[r] & width_mask(w);
  endfunction

  function automatic logic [3:0] arith_nzcv(logic [63:0] a, logic [63:0] b,
                                            logic [63:0] sum, bit is_sub, bit w);
    logic [63:0] m;
    bit c, v, sa, sb, sr;
    m  = width_mask(w);
    sa = sign_of(a, w);
    sb = sign_of(b, w);
    sr = sign_of(sum, w);
    if (is_sub) begin
      c = (a & m) >= (b & m);
      v = (sa != sb) && (sr == sb);
    end else begin
      c = (sum & m) < (a & m);
      v = (sa == sb) && (sr != sa);
    end
    return {sr, (sum & m) == 0, c, v};
  endfunction

  // only the low 5 bits of the distance count in 32-bit mode
  function automatic logic [63:0] shift_operand(logic [63:0] v, logic [1:0] kind,
                                                logic [5:0] amt, bit w);
    int bits, n;
    logic [63:0] m, r;
    bits = w ? 64 : 32;
    m    = width_mask(w);
    n    = amt & (bits - 1);
    v    = v & m;
    if (n == 0) return v;
    case (kind)
      aiex_pkg::SH_LSL: return (v << n) & m;
      aiex_pkg::SH_LSR: return v >> n;
      aiex_pkg::SH_ASR: begin
        r = v >> n;
        if (sign_of(v, w)) r = r | ((m << (bits - n)) & m);
        return r;
      end
      default: return ((v >> n) | (v << (bits - n))) & m;
    endcase
  endfunction

  function automatic writeback_t compute_writeback(exec_req_t r);
    logic [63:0] m, a, b, val, moved, acc;
    int          sh;
    bit          wr;
    logic [1:0]  err;
    writeback_t  res;
    m   = width_mask(r.wide_64);
    wr  = 1'b0;
    val = '0;
    err = aiex_pkg::ERR_NONE;
    if (!model_halt) begin
      a = read_model_reg(r.first_reg, r.wide_64);
      case (r.opcode)
        aiex_pkg::OP_IMM_ARITH: begin
          // bits 15:12 of the immediate and bit 1 of the position are don't-care
          b = {52'd0, r.immediate[11:0]};
          if (r.imm_position[0]) b = b << 12;
          val = r.op_variant[1] ? a - b : a + b;
          wr  = 1'b1;
          if (r.op_variant[0]) model_nzcv = arith_nzcv(a, b, val, r.op_variant[1], r.wide_64);
        end
        aiex_pkg::OP_WIDE_MOVE: begin
          if (!r.wide_64 && r.imm_position >= 2) begin
            err = aiex_pkg::ERR_WIDE_POS;
          end else begin
            sh    = r.imm_position * aiex_pkg::HALF_SHIFT;
            moved = {48'd0, r.immediate} << sh;
            case (r.op_variant)
              aiex_pkg::MOV_N: begin val = ~moved; wr = 1'b1; end
              aiex_pkg::MOV_Z: begin val = moved;  wr = 1'b1; end
              aiex_pkg::MOV_K: begin
                val = (read_model_reg(r.dest_reg, r.wide_64) & ~(64'hFFFF << sh)) | moved;
                wr  = 1'b1;
              end
              default: ;
            endcase
          end
        end
        aiex_pkg::OP_REG_ARITH: begin
          if (r.shift_kind == aiex_pkg::SH_ROR) begin
            err        = aiex_pkg::ERR_ROTATE;
            model_halt = 1'b1;
          end else begin
            b = shift_operand(read_model_reg(r.second_reg, r.wide_64), r.shift_kind,
                              r.shift_amount, r.wide_64);
            val = r.op_variant[1] ? a - b : a + b;
            wr  = 1'b1;
            if (r.op_variant[0]) model_nzcv = arith_nzcv(a, b, val, r.op_variant[1], r.wide_64);
          end
        end
        aiex_pkg::OP_REG_LOGIC: begin
          b = shift_operand(read_model_reg(r.second_reg, r.wide_64), r.shift_kind,
                            r.shift_amount, r.wide_64);
          if (r.invert) b = ~b & m;
          case (r.op_variant)
            aiex_pkg::LOG_ORR: val = a | b;
            aiex_pkg::LOG_EOR: val = a ^ b;
            default:           val = a & b;
          endcase
          wr = 1'b1;
          if (r.op_variant == aiex_pkg::LOG_ANDS)
            model_nzcv = {sign_of(val, r.wide_64), (val & m) == 0, 2'b00};
        end
        aiex_pkg::OP_MULTIPLY: begin
          if (r.op_variant != MUL_ACC) begin
            err        = aiex_pkg::ERR_UNDEF;
            model_halt = 1'b1;
          end else begin
            b   = read_model_reg(r.second_reg, r.wide_64);
            acc = read_model_reg(r.addend_reg, r.wide_64);
            val = r.invert ? acc - a * b : acc + a * b;
            wr  = 1'b1;
          end
        end
        default: begin
          err        = aiex_pkg::ERR_UNDEF;
          model_halt = 1'b1;
        end
      endcase
    end
    val = val & m;
    if (wr && r.dest_reg < NREGS) begin
      model_regs[r.dest_reg] = val;
    end else begin
      wr  = 1'b0;
      val = '0;
    end
    res.write_enable  = wr;
    res.written_reg   = wr ? r.dest_reg : 5'd0;
    res.written_value = val;
    res.flags_nzcv    = model_nzcv;
    res.error_code    = err;
    res.halted        = model_halt;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------
  // Offers one request from a falling edge, holds it until a rising edge takes
  // it, then works out its writeback. Valid stays high on return so that
  // back-to-back requests leave no gap.
  task automatic send_request(exec_req_t r);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    opcode       <= r.opcode;
    wide_64      <= r.wide_64;
    op_variant   <= r.op_variant;
    dest_reg     <= r.dest_reg;
    first_reg    <= r.first_reg;
    second_reg   <= r.second_reg;
    addend_reg   <= r.addend_reg;
    shift_kind   <= r.shift_kind;
    shift_amount <= r.shift_amount;
    invert       <= r.invert;
    immediate    <= r.immediate;
    imm_position <= r.imm_position;
    do @(posedge clk); while (in_stall);
    pending_writebacks.push_back(compute_writeback(r));
  endtask

  // Sender goes quiet until every outstanding writeback has been seen
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_writebacks.size() != 0) @(posedge clk);
  endtask

  function automatic exec_req_t directed_request(
      logic [2:0] op, logic w, logic [1:0] variant, logic [4:0] rd, logic [4:0] rn,
      logic [4:0] rm, logic [4:0] ra, logic [1:0] kind, logic [5:0] amt, logic inv,
      logic [15:0] imm, logic [1:0] pos);
    exec_req_t r;
    r.opcode       = op;
    r.wide_64      = w;
    r.op_variant   = variant;
    r.dest_reg     = rd;
    r.first_reg    = rn;
    r.second_reg   = rm;
    r.addend_reg   = ra;
    r.shift_kind   = kind;
    r.shift_amount = amt;
    r.invert       = inv;
    r.immediate    = imm;
    r.imm_position = pos;
    return r;
  endfunction

  // Mostly low registers so that results feed straight into later operands
  function automatic logic [4:0] pick_reg();
    int p;
    p = $urandom_range(99);
    if (p < 70) return 5'($urandom_range(7));
    if (p < 80) return ZERO_REG;
    return 5'($urandom_range(31));
  endfunction

  // A well-formed request that never halts the block
  function automatic exec_req_t random_request();
    exec_req_t r;
    int p;
    p = $urandom_range(99);
    if (p < 20)      r.opcode = aiex_pkg::OP_IMM_ARITH;
    else if (p < 45) r.opcode = aiex_pkg::OP_WIDE_MOVE;
    else if (p < 65) r.opcode = aiex_pkg::OP_REG_ARITH;
    else if (p < 85) r.opcode = aiex_pkg::OP_REG_LOGIC;
    else             r.opcode = aiex_pkg::OP_MULTIPLY;
    r.wide_64    = ($urandom_range(3) != 0);
    r.op_variant = 2'($urandom_range(3));
    if (r.opcode == aiex_pkg::OP_MULTIPLY) r.op_variant = MUL_ACC;
    r.dest_reg   = pick_reg();
    r.first_reg  = pick_reg();
    r.second_reg = pick_reg();
    r.addend_reg = pick_reg();
    r.shift_kind = 2'($urandom_range(3));
    if (r.opcode == aiex_pkg::OP_REG_ARITH && r.shift_kind == aiex_pkg::SH_ROR)
      r.shift_kind = 2'($urandom_range(2));
    p = $urandom_range(9);
    if (p == 0)      r.shift_amount = 6'd0;
    else if (p == 1) r.shift_amount = 6'd63;
    else             r.shift_amount = 6'($urandom_range(63));
    r.invert = 1'($urandom_range(1));
    p = $urandom_range(9);
    if (p == 0)      r.immediate = 16'h0000;
    else if (p == 1) r.immediate = 16'hFFFF;
    else             r.immediate = 16'($urandom_range(16'hFFFF));
    r.imm_position = 2'($urandom_range(3));
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------
  // Receiver stall, changed on the falling edge; a forced hold wins over chance
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    mismatch_count++;
    $display("mismatch at cycle %0d: %s got %0h want %0h", cycle_count, what, got, want);
  endtask

  // Every accepted writeback is checked against the oldest prediction
  always @(posedge clk) begin : writeback_check
    writeback_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_writebacks.size() == 0) begin
        report_mismatch("writeback with no request outstanding, value", written_value, '0);
      end else begin
        want = pending_writebacks.pop_front();
        if (write_enable !== want.write_enable)
          report_mismatch("write_enable", write_enable, want.write_enable);
        if (written_reg !== want.written_reg)
          report_mismatch("written_reg", written_reg, want.written_reg);
        if (written_value !== want.written_value)
          report_mismatch("written_value", written_value, want.written_value);
        if (flags_nzcv !== want.flags_nzcv)
          report_mismatch("flags_nzcv", flags_nzcv, want.flags_nzcv);
        if (error_code !== want.error_code)
          report_mismatch("error_code", error_code, want.error_code);
        if (halted !== want.halted)
          report_mismatch("halted", halted, want.halted);
      end
    end
  end

  // Watchdog: a hung handshake ends the run here
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Field extremes, every operation and the named corner cases, none of which halts
  task automatic test_directed();
    exec_req_t list [$];
    list.push_back(directed_request(aiex_pkg::OP_WIDE_MOVE, 1, aiex_pkg::MOV_Z, 1, 0, 0, 0,
                                    aiex_pkg::SH_LSL, 0, 0, 16'hFFFF, 3));
    list.push_back(directed_request(aiex_pkg::OP_WIDE_MOVE, 1, aiex_pkg::MOV_K, 1, 0, 0, 0,
                                    aiex_pkg::SH_LSL, 0, 0, 16'hFFFF, 0));
    list.push_back(directed_request(aiex_pkg::OP_WIDE_MOVE, 1, aiex_pkg::MOV_N, 2, 0, 0, 0,
                                    aiex_pkg::SH_LSL, 0, 0, 16'h0000, 0));
    list.push_back(directed_request(aiex_pkg::OP_WIDE_MOVE, 0, aiex_pkg::MOV_N, 3, 0, 0, 0,
                                    aiex_pkg::SH_LSL, 0, 0, 16'h8000, 1));
    list.push_back(directed_request(aiex_pkg::OP_WIDE_MOVE, 1, aiex_pkg::MOV_Z, 4, 0, 0, 0,
                                    aiex_pkg::SH_LSL, 0, 0, 16'h8000, 3));
    // variant one of the wide move writes nothing and is no error
    list.push_back(directed_request(aiex_pkg::OP_WIDE_MOVE, 1, MOV_NONE, 5, 0, 0, 0,
                                    aiex_pkg::SH_LSL, 0, 0, 16'h1234, 1));
    // halfword 2 in 32-bit mode: error without a halt
    list.push_back(directed_request(aiex_pkg::OP_WIDE_MOVE, 0, aiex_pkg::MOV_Z, 5, 0, 0, 0,
                                    aiex_pkg::SH_LSL, 0, 0, 16'h1234, 2));
    // all ones plus one: carry out and zero
    list.push_back(directed_request(aiex_pkg::OP_IMM_ARITH, 1, ARITH_ADDS, 6, 2, 0, 0,
                                    aiex_pkg::SH_LSL, 0, 0, 16'h0001, 0));
    // immediate top nibble and position bit 1 must be ignored
    list.push_back(directed_request(aiex_pkg::OP_IMM_ARITH, 0, ARITH_SUBS, 7, 3, 0, 0,
                                    aiex_pkg::SH_LSL, 0, 0, 16'hFFFF, 3));
    // most negative plus itself: signed overflow
    list.push_back(directed_request(aiex_pkg::OP_REG_ARITH, 1, ARITH_ADDS, 8, 4, 4, 0,
                                    aiex_pkg::SH_LSL, 0, 0, 0, 0));
    // 32-bit distance 63 counts as 31
    list.push_back(directed_request(aiex_pkg::OP_REG_ARITH, 0, ARITH_SUBS, 9, 3, 2, 0,
                                    aiex_pkg::SH_LSR, 63, 0, 0, 0));
    list.push_back(directed_request(aiex_pkg::OP_REG_ARITH, 1, ARITH_ADD, 10, 0, 4, 0,
                                    aiex_pkg::SH_ASR, 63, 0, 0, 0));
    list.push_back(directed_request(aiex_pkg::OP_REG_ARITH, 1, ARITH_SUB, 11, 1, 2, 0,
                                    aiex_pkg::SH_LSL, 63, 0, 0, 0));
    list.push_back(directed_request(aiex_pkg::OP_REG_ARITH, 0, ARITH_SUBS, 12, ZERO_REG, 3, 0,
                                    aiex_pkg::SH_ASR, 4, 0, 0, 0));
    // rotate by zero leaves the operand alone
    list.push_back(directed_request(aiex_pkg::OP_REG_LOGIC, 1, LOG_AND, 13, 1, 2, 0,
                                    aiex_pkg::SH_ROR, 0, 1, 0, 0));
    list.push_back(directed_request(aiex_pkg::OP_REG_LOGIC, 1, aiex_pkg::LOG_ORR, 14, 0, 4, 0,
                                    aiex_pkg::SH_ROR, 1, 0, 0, 0));
    list.push_back(directed_request(aiex_pkg::OP_REG_LOGIC, 0, aiex_pkg::LOG_EOR, 15, 1, 3, 0,
                                    aiex_pkg::SH_ROR, 63, 1, 0, 0));
    list.push_back(directed_request(aiex_pkg::OP_REG_LOGIC, 1, aiex_pkg::LOG_ANDS, 16, 1, 2, 0,
                                    aiex_pkg::SH_LSL, 0, 0, 0, 0));
    list.push_back(directed_request(aiex_pkg::OP_REG_LOGIC, 1, aiex_pkg::LOG_ANDS, 17, 4, 3, 0,
                                    aiex_pkg::SH_LSR, 0, 0, 0, 0));
    list.push_back(directed_request(aiex_pkg::OP_MULTIPLY, 1, MUL_ACC, 18, 1, 2, 3,
                                    aiex_pkg::SH_LSL, 0, 0, 0, 0));
    list.push_back(directed_request(aiex_pkg::OP_MULTIPLY, 0, MUL_ACC, 19, 3, 2, 3,
                                    aiex_pkg::SH_LSL, 0, 1, 0, 0));
    // write to the zero register is dropped
    list.push_back(directed_request(aiex_pkg::OP_IMM_ARITH, 1, ARITH_ADDS, ZERO_REG, 1, 0, 0,
                                    aiex_pkg::SH_LSL, 0, 0, 16'h0FFF, 1));
    // zero register as both sources, second one inverted
    list.push_back(directed_request(aiex_pkg::OP_REG_LOGIC, 1, aiex_pkg::LOG_ORR, 20, ZERO_REG,
                                    ZERO_REG, 0, aiex_pkg::SH_LSL, 0, 1, 0, 0));
    // 32-bit rotate by 32 is a rotate by zero
    list.push_back(directed_request(aiex_pkg::OP_REG_LOGIC, 0, aiex_pkg::LOG_EOR, 21, 1, 1, 0,
                                    aiex_pkg::SH_ROR, 32, 0, 0, 0));
    list.push_back(directed_request(aiex_pkg::OP_WIDE_MOVE, 0, aiex_pkg::MOV_K, 1, 0, 0, 0,
                                    aiex_pkg::SH_LSL, 0, 0, 16'hA5C3, 1));
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    foreach (list[i]) send_request(list[i]);
    drain_results();
  endtask

  task automatic test_random_phase(int count, int idle_pct, int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) send_request(random_request());
    drain_results();
  endtask

  // Receiver holds off long enough for the block to fill and stall its input
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left      = 80;
    repeat (40) send_request(random_request());
    drain_results();
  endtask

  // One halting request picked at random, then requests the block must ignore
  task automatic test_halt_and_ignore();
    exec_req_t r;
    int choice;
    send_idle_pct  = 20;
    recv_stall_pct = 20;
    r      = random_request();
    choice = $urandom_range(2);
    if (choice == 0) begin
      r.opcode     = aiex_pkg::OP_REG_ARITH;
      r.shift_kind = aiex_pkg::SH_ROR;
    end else if (choice == 1) begin
      r.opcode = 3'($urandom_range(OP_UNDEF_FIRST, OP_UNDEF_LAST));
    end else begin
      r.opcode     = aiex_pkg::OP_MULTIPLY;
      r.op_variant = 2'($urandom_range(3, 1));
    end
    send_request(r);
    repeat (15) begin
      r = random_request();
      if ($urandom_range(1)) r.opcode = 3'($urandom_range(7));
      send_request(r);
    end
    drain_results();
  endtask

  initial begin
    foreach (model_regs[i]) model_regs[i] = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_random_phase(150, 0, 0);
    test_random_phase(150, 75, 0);
    test_random_phase(150, 0, 75);
    test_random_phase(150, 6, 6);
    test_backpressure();
    test_halt_and_ignore();

    // settle time for anything still in the pipe
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
